>>> design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/mppt_po_pkg.sv
// Types, constants and register codes of the perturb-and-observe MPPT controller.
package mppt_po_pkg;

    localparam int DUTY_BITS_DEFAULT = 10;
    localparam int LIMIT_BITS = 10;
    localparam int PANEL_BITS = 16;
    localparam int BATTERY_BITS = 16;
    localparam int CURRENT_BITS = 12;
    localparam int MODE_BITS = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_VOLTAGE_MIN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BATTERY_VOLTAGE_MAX = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHARGE_CURRENT_MIN = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_LOWER_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_UPPER_LIMIT = 3'd4;

    localparam logic [PANEL_BITS-1:0] PANEL_VOLTAGE_MIN_RESET = 16'd12000;
    localparam logic [BATTERY_BITS-1:0] BATTERY_VOLTAGE_MAX_RESET = 16'd14400;
    localparam logic [CURRENT_BITS-1:0] CHARGE_CURRENT_MIN_RESET = 12'd20;
    localparam logic [LIMIT_BITS-1:0] DUTY_LOWER_LIMIT_RESET = 10'd100;
    localparam logic [LIMIT_BITS-1:0] DUTY_UPPER_LIMIT_RESET = 10'd900;

    localparam logic [MODE_BITS-1:0] MODE_SHUTDOWN = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_INC = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEC = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_CV = 2'd3;

    typedef enum logic [3:0] {
        ST_SHUTDOWN = 4'b0001,
        ST_INC      = 4'b0010,
        ST_DEC      = 4'b0100,
        ST_CV       = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic [PANEL_BITS-1:0]   panel_voltage_min;
        logic [BATTERY_BITS-1:0] battery_voltage_max;
        logic [CURRENT_BITS-1:0] charge_current_min;
        logic [LIMIT_BITS-1:0]   duty_lower_limit;
        logic [LIMIT_BITS-1:0]   duty_upper_limit;
    } cfg_t;

    typedef struct packed {
        logic [PANEL_BITS-1:0]   panel_mv;
        logic [BATTERY_BITS-1:0] battery_mv;
        logic [CURRENT_BITS-1:0] charge_ma;
    } tick_t;

    typedef struct packed {
        logic pwm_start;
        logic postpone;
    } step_flags_t;

endpackage

>>> design/mppt_po_if.sv
// Handshake interfaces for the measurement tick channel and the result channel.
interface mppt_po_tick_if;
    logic                                 valid;
    logic                                 ready;
    logic [mppt_po_pkg::PANEL_BITS-1:0]   panel_mv;
    logic [mppt_po_pkg::BATTERY_BITS-1:0] battery_mv;
    logic [mppt_po_pkg::CURRENT_BITS-1:0] charge_ma;

    modport source (output valid, output panel_mv, output battery_mv, output charge_ma,
                    input ready);
    modport sink (input valid, input panel_mv, input battery_mv, input charge_ma,
                  output ready);
endinterface

interface mppt_po_result_if #(
    parameter int DUTY_BITS = mppt_po_pkg::DUTY_BITS_DEFAULT
);
    logic                              valid;
    logic                              ready;
    logic [mppt_po_pkg::MODE_BITS-1:0] mode;
    logic [DUTY_BITS-1:0]              duty;
    logic                              pwm_enable;
    logic                              pwm_start;
    logic                              postpone;

    modport source (output valid, output mode, output duty, output pwm_enable,
                    output pwm_start, output postpone, input ready);
    modport sink (input valid, input mode, input duty, input pwm_enable,
                  input pwm_start, input postpone, output ready);
endinterface

>>> design/mppt_perturb_observe_controller_top.sv
// Top level of the perturb-and-observe MPPT charge controller.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result is not stalled; the state loop closes through the state register.
// A stalled result holds both registers; the tick side stays ready while a slot is free.
// Reset clears the mode to shutdown, the duty and last battery voltage to zero,
// and loads the configuration registers with their reset values.
`include "assert_macros.svh"

module mppt_perturb_observe_controller_top #(
    parameter int DUTY_BITS = mppt_po_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    mppt_po_tick_if.sink                           tick,
    mppt_po_result_if.source                       result,
    input  logic                                   cfg_we,
    input  logic [mppt_po_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mppt_po_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mppt_po_pkg::cfg_t                    cfg;
    mppt_po_pkg::tick_t                   tick_reg;
    logic                                 tick_valid_reg;
    mppt_po_pkg::ctrl_state_t             state_reg;
    mppt_po_pkg::ctrl_state_t             state_next;
    logic [DUTY_BITS-1:0]                 duty_reg;
    logic [DUTY_BITS-1:0]                 duty_next;
    logic [mppt_po_pkg::BATTERY_BITS-1:0] last_battery_reg;
    mppt_po_pkg::step_flags_t             flags;
    logic                                 out_valid_reg;
    logic [mppt_po_pkg::MODE_BITS-1:0]    out_mode_reg;
    logic [mppt_po_pkg::MODE_BITS-1:0]    mode_next;
    logic [DUTY_BITS-1:0]                 out_duty_reg;
    mppt_po_pkg::step_flags_t             out_flags_reg;
    logic                                 advance;
    logic                                 fire;

    mppt_po_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mppt_po_step #(
        .DUTY_BITS (DUTY_BITS)
    ) u_step (
        .cfg             (cfg),
        .tick            (tick_reg),
        .state           (state_reg),
        .duty            (duty_reg),
        .last_battery_mv (last_battery_reg),
        .state_next      (state_next),
        .duty_next       (duty_next),
        .flags           (flags)
    );

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = tick_valid_reg && advance;
    assign tick.ready = !tick_valid_reg || advance;

    always_comb
    begin
        case (state_next)
            mppt_po_pkg::ST_SHUTDOWN: mode_next = mppt_po_pkg::MODE_SHUTDOWN;
            mppt_po_pkg::ST_INC:      mode_next = mppt_po_pkg::MODE_INC;
            mppt_po_pkg::ST_DEC:      mode_next = mppt_po_pkg::MODE_DEC;
            default:                  mode_next = mppt_po_pkg::MODE_CV;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= mppt_po_pkg::ST_SHUTDOWN;
            duty_reg         <= '0;
            last_battery_reg <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                tick_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= tick_valid_reg;
            end
            if (fire)
            begin
                state_reg        <= state_next;
                duty_reg         <= duty_next;
                last_battery_reg <= tick_reg.battery_mv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tick_reg.panel_mv   <= tick.panel_mv;
            tick_reg.battery_mv <= tick.battery_mv;
            tick_reg.charge_ma  <= tick.charge_ma;
        end
        if (fire)
        begin
            out_mode_reg  <= mode_next;
            out_duty_reg  <= duty_next;
            out_flags_reg <= flags;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.mode       = out_mode_reg;
    assign result.duty       = out_duty_reg;
    assign result.pwm_enable = out_mode_reg != mppt_po_pkg::MODE_SHUTDOWN;
    assign result.pwm_start  = out_flags_reg.pwm_start;
    assign result.postpone   = out_flags_reg.postpone;

    `ASSERT_IMPLIES(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `ASSERT_NEVER(a_start_and_postpone, clk, rst_n,
                  out_valid_reg && out_flags_reg.pwm_start && out_flags_reg.postpone)
    `ASSERT_IMPLIES(a_start_enters_dec, clk, rst_n, out_valid_reg && out_flags_reg.pwm_start,
                    out_mode_reg == mppt_po_pkg::MODE_DEC)
    `ASSERT_IMPLIES(a_postpone_is_shutdown, clk, rst_n, out_valid_reg && out_flags_reg.postpone,
                    out_mode_reg == mppt_po_pkg::MODE_SHUTDOWN)
    `ASSERT_IMPLIES(a_state_holds_idle, clk, rst_n, !fire, ##1 state_reg == $past(state_reg))

endmodule

>>> design/mppt_po_cfg.sv
// Configuration register file with its reset values.
module mppt_po_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mppt_po_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mppt_po_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output mppt_po_pkg::cfg_t                      cfg
);

    mppt_po_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_voltage_min   <= mppt_po_pkg::PANEL_VOLTAGE_MIN_RESET;
            cfg_reg.battery_voltage_max <= mppt_po_pkg::BATTERY_VOLTAGE_MAX_RESET;
            cfg_reg.charge_current_min  <= mppt_po_pkg::CHARGE_CURRENT_MIN_RESET;
            cfg_reg.duty_lower_limit    <= mppt_po_pkg::DUTY_LOWER_LIMIT_RESET;
            cfg_reg.duty_upper_limit    <= mppt_po_pkg::DUTY_UPPER_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mppt_po_pkg::CFG_PANEL_VOLTAGE_MIN:
                    cfg_reg.panel_voltage_min <= cfg_data[mppt_po_pkg::PANEL_BITS-1:0];
                mppt_po_pkg::CFG_BATTERY_VOLTAGE_MAX:
                    cfg_reg.battery_voltage_max <= cfg_data[mppt_po_pkg::BATTERY_BITS-1:0];
                mppt_po_pkg::CFG_CHARGE_CURRENT_MIN:
                    cfg_reg.charge_current_min <= cfg_data[mppt_po_pkg::CURRENT_BITS-1:0];
                mppt_po_pkg::CFG_DUTY_LOWER_LIMIT:
                    cfg_reg.duty_lower_limit <= cfg_data[mppt_po_pkg::LIMIT_BITS-1:0];
                mppt_po_pkg::CFG_DUTY_UPPER_LIMIT:
                    cfg_reg.duty_upper_limit <= cfg_data[mppt_po_pkg::LIMIT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/mppt_po_step.sv
// Next-state logic of the controller for one measurement tick.
module mppt_po_step #(
    parameter int DUTY_BITS = mppt_po_pkg::DUTY_BITS_DEFAULT
) (
    input  mppt_po_pkg::cfg_t                    cfg,
    input  mppt_po_pkg::tick_t                   tick,
    input  mppt_po_pkg::ctrl_state_t             state,
    input  logic [DUTY_BITS-1:0]                 duty,
    input  logic [mppt_po_pkg::BATTERY_BITS-1:0] last_battery_mv,
    output mppt_po_pkg::ctrl_state_t             state_next,
    output logic [DUTY_BITS-1:0]                 duty_next,
    output mppt_po_pkg::step_flags_t             flags
);

    localparam int CW = (DUTY_BITS > mppt_po_pkg::LIMIT_BITS) ? DUTY_BITS
                                                               : mppt_po_pkg::LIMIT_BITS;
    localparam logic [DUTY_BITS-1:0] DUTY_TOP = {DUTY_BITS{1'b1}};

    logic [CW-1:0]        duty_ext;
    logic [CW-1:0]        lower_ext;
    logic [CW-1:0]        upper_ext;
    logic [CW-1:0]        top_ext;
    logic [DUTY_BITS-1:0] duty_up;
    logic [DUTY_BITS-1:0] duty_down;
    logic [DUTY_BITS-1:0] duty_start;
    logic [DUTY_BITS-1:0] duty_cv_entry;
    logic                 battery_fell;
    logic                 battery_at_max;

    assign duty_ext  = CW'(duty);
    assign lower_ext = CW'(cfg.duty_lower_limit);
    assign upper_ext = CW'(cfg.duty_upper_limit);
    assign top_ext   = CW'(DUTY_TOP);

    assign duty_up       = (duty == DUTY_TOP) ? DUTY_TOP : duty + 1'b1;
    assign duty_down     = (duty == '0) ? '0 : duty - 1'b1;
    assign duty_start    = (upper_ext < top_ext) ? upper_ext[DUTY_BITS-1:0] : DUTY_TOP;
    assign duty_cv_entry = (duty_ext > lower_ext) ? duty - 1'b1 : lower_ext[DUTY_BITS-1:0];

    assign battery_fell   = tick.battery_mv < last_battery_mv;
    assign battery_at_max = tick.battery_mv >= cfg.battery_voltage_max;

    always_comb
    begin
        state_next      = state;
        duty_next       = duty;
        flags.pwm_start = 1'b0;
        flags.postpone  = 1'b0;
        case (state)
            mppt_po_pkg::ST_SHUTDOWN:
            begin
                if (tick.panel_mv > cfg.panel_voltage_min && !battery_at_max)
                begin
                    state_next      = mppt_po_pkg::ST_DEC;
                    duty_next       = duty_start;
                    flags.pwm_start = 1'b1;
                end
            end
            mppt_po_pkg::ST_INC, mppt_po_pkg::ST_DEC:
            begin
                if (tick.charge_ma < cfg.charge_current_min)
                begin
                    state_next     = mppt_po_pkg::ST_SHUTDOWN;
                    flags.postpone = 1'b1;
                end
                else if (battery_at_max)
                begin
                    state_next = mppt_po_pkg::ST_CV;
                    duty_next  = duty_cv_entry;
                end
                else if (state == mppt_po_pkg::ST_DEC)
                begin
                    if (battery_fell || duty_ext <= lower_ext)
                    begin
                        state_next = mppt_po_pkg::ST_INC;
                        duty_next  = duty_up;
                    end
                    else
                    begin
                        duty_next = duty_down;
                    end
                end
                else
                begin
                    if (battery_fell || duty_ext >= upper_ext)
                    begin
                        state_next = mppt_po_pkg::ST_DEC;
                        duty_next  = duty_down;
                    end
                    else
                    begin
                        duty_next = duty_up;
                    end
                end
            end
            default:
            begin
                if (!battery_at_max)
                begin
                    if (duty_ext < upper_ext)
                    begin
                        duty_next = duty_up;
                    end
                    else
                    begin
                        state_next = mppt_po_pkg::ST_DEC;
                    end
                end
                else if (duty_ext > lower_ext)
                begin
                    duty_next = duty_down;
                end
                else
                begin
                    state_next     = mppt_po_pkg::ST_SHUTDOWN;
                    flags.postpone = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> tb/mppt_perturb_observe_controller_top_test.sv
// Self-checking testbench: drives measurement ticks and checks every controller result.
module mppt_perturb_observe_controller_top_test;
    import mppt_po_pkg::*;

    localparam int DUTY_BITS = DUTY_BITS_DEFAULT;
    localparam int unsigned MV_TOP = (1 << BATTERY_BITS) - 1;
    localparam int unsigned MA_TOP = (1 << CURRENT_BITS) - 1;
    localparam int unsigned LIMIT_TOP = (1 << LIMIT_BITS) - 1;
    localparam int unsigned CFG_INDEX_TOP = (1 << CFG_INDEX_BITS) - 1;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [DUTY_BITS-1:0] duty;
        logic                 pwm_enable;
        step_flags_t          flags;
    } outcome_t;

    typedef enum int {
        DRIFT_WANDER,
        DRIFT_CLIMB,
        DRIFT_SAG
    } drift_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    mppt_po_tick_if tick_ch();
    mppt_po_result_if #(.DUTY_BITS(DUTY_BITS)) result_ch();

    mppt_perturb_observe_controller_top #(
        .DUTY_BITS(DUTY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .tick(tick_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cfg_t limits;
    logic [MODE_BITS-1:0] ctl_mode;
    logic [DUTY_BITS-1:0] ctl_duty;
    logic [BATTERY_BITS-1:0] prev_battery_mv;

    tick_t tick_backlog[$];
    outcome_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ticks_queued = 0;
    int settings_applied = 0;
    int results_checked = 0;
    int starts_seen = 0;
    int shutdowns_seen = 0;
    int cv_results = 0;
    int mismatches = 0;

    function automatic int unsigned nudge_up(int unsigned d, int unsigned top);
        return (d < top) ? d + 1 : top;
    endfunction

    function automatic int unsigned nudge_down(int unsigned d);
        return (d > 0) ? d - 1 : 0;
    endfunction

    function automatic outcome_t advance_controller(tick_t t);
        outcome_t o;
        int unsigned d;
        int unsigned lo;
        int unsigned hi;
        int unsigned top;
        logic [MODE_BITS-1:0] m;
        o = '0;
        d = ctl_duty;
        lo = limits.duty_lower_limit;
        hi = limits.duty_upper_limit;
        top = (1 << DUTY_BITS) - 1;
        m = ctl_mode;
        case (ctl_mode)
            MODE_SHUTDOWN:
            begin
                if (t.panel_mv > limits.panel_voltage_min &&
                    t.battery_mv < limits.battery_voltage_max)
                begin
                    m = MODE_DEC;
                    d = (hi < top) ? hi : top;
                    o.flags.pwm_start = 1'b1;
                end
            end
            MODE_INC, MODE_DEC:
            begin
                if (t.charge_ma < limits.charge_current_min)
                begin
                    m = MODE_SHUTDOWN;
                    o.flags.postpone = 1'b1;
                end
                else if (t.battery_mv >= limits.battery_voltage_max)
                begin
                    m = MODE_CV;
                    d = (d > lo) ? d - 1 : lo;
                end
                else if (ctl_mode == MODE_DEC)
                begin
                    if (t.battery_mv < prev_battery_mv || d <= lo)
                    begin
                        m = MODE_INC;
                        d = nudge_up(d, top);
                    end
                    else
                        d = nudge_down(d);
                end
                else
                begin
                    if (t.battery_mv < prev_battery_mv || d >= hi)
                    begin
                        m = MODE_DEC;
                        d = nudge_down(d);
                    end
                    else
                        d = nudge_up(d, top);
                end
            end
            default:
            begin
                if (t.battery_mv < limits.battery_voltage_max)
                begin
                    if (d < hi)
                        d = nudge_up(d, top);
                    else
                        m = MODE_DEC;
                end
                else if (d > lo)
                    d = nudge_down(d);
                else
                begin
                    m = MODE_SHUTDOWN;
                    o.flags.postpone = 1'b1;
                end
            end
        endcase
        ctl_mode = m;
        ctl_duty = DUTY_BITS'(d & top);
        prev_battery_mv = t.battery_mv;
        o.mode = m;
        o.duty = ctl_duty;
        o.pwm_enable = (m != MODE_SHUTDOWN);
        return o;
    endfunction

    function automatic cfg_t make_limits(int unsigned pv, int unsigned bv, int unsigned ic,
                                         int unsigned lo, int unsigned hi);
        cfg_t c;
        c.panel_voltage_min = PANEL_BITS'(pv);
        c.battery_voltage_max = BATTERY_BITS'(bv);
        c.charge_current_min = CURRENT_BITS'(ic);
        c.duty_lower_limit = LIMIT_BITS'(lo);
        c.duty_upper_limit = LIMIT_BITS'(hi);
        return c;
    endfunction

    function automatic cfg_t random_limits();
        int unsigned lo;
        int unsigned hi;
        lo = $urandom_range(LIMIT_TOP);
        case ($urandom_range(2))
            0: hi = (lo + $urandom_range(12) > LIMIT_TOP) ? LIMIT_TOP : lo + $urandom_range(12);
            1: hi = $urandom_range(LIMIT_TOP);
            default: hi = (lo > 0) ? $urandom_range(lo - 1) : 0;
        endcase
        return make_limits($urandom_range(30000), $urandom_range(MV_TOP, 1000),
                           $urandom_range(200), lo, hi);
    endfunction

    // Values cluster near both ends of the range so that every threshold compare flips.
    function automatic int unsigned pick_range(int unsigned a, int unsigned b);
        int unsigned span;
        if (b <= a)
            return a;
        span = b - a;
        case ($urandom_range(2))
            0: return a + $urandom_range((span < 40) ? span : 40);
            1: return b - $urandom_range((span < 40) ? span : 40);
            default: return $urandom_range(b, a);
        endcase
    endfunction

    function automatic int unsigned pick_above(int unsigned x, int unsigned top);
        return (x >= top) ? top : pick_range(x + 1, top);
    endfunction

    function automatic int unsigned pick_below(int unsigned x);
        return (x == 0) ? 0 : pick_range(0, x - 1);
    endfunction

    task automatic add_tick(int unsigned pv, int unsigned bv, int unsigned ic);
        tick_t t;
        t.panel_mv = PANEL_BITS'(pv);
        t.battery_mv = BATTERY_BITS'(bv);
        t.charge_ma = CURRENT_BITS'(ic);
        tick_backlog.push_back(t);
        ticks_queued++;
    endtask

    // One charging session: a start tick, then tracking with a drifting battery voltage,
    // sprinkled with voltage-limit hits and low-current dropouts.
    task automatic queue_session(int len);
        int unsigned bv_walk;
        int unsigned ceiling;
        int unsigned step;
        int r;
        drift_t drift;
        ceiling = (limits.battery_voltage_max > 0) ? limits.battery_voltage_max - 1 : 0;
        bv_walk = pick_range(0, ceiling);
        drift = drift_t'($urandom_range(2));
        add_tick(pick_above(limits.panel_voltage_min, MV_TOP), bv_walk,
                 pick_range(limits.charge_current_min, MA_TOP));
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                add_tick($urandom, bv_walk, pick_below(limits.charge_current_min));
            else if (r < 10)
                add_tick($urandom, pick_range(limits.battery_voltage_max, MV_TOP), $urandom);
            else if (r < 12)
            begin
                repeat ($urandom_range(30, 5))
                    add_tick($urandom, pick_range(limits.battery_voltage_max, MV_TOP),
                             pick_range(limits.charge_current_min, MA_TOP));
            end
            else
            begin
                step = $urandom_range(24);
                case (drift)
                    DRIFT_CLIMB: bv_walk = bv_walk + step;
                    DRIFT_SAG: bv_walk = (bv_walk > step) ? bv_walk - step : 0;
                    default:
                    begin
                        if ($urandom_range(1))
                            bv_walk = bv_walk + step;
                        else
                            bv_walk = (bv_walk > step) ? bv_walk - step : 0;
                    end
                endcase
                if (bv_walk > ceiling)
                    bv_walk = ceiling;
                add_tick($urandom, bv_walk, pick_range(limits.charge_current_min, MA_TOP));
            end
        end
    endtask

    task automatic queue_random(int count);
        int target;
        int len;
        target = ticks_queued + count;
        while (ticks_queued < target)
        begin
            if ($urandom_range(99) < 88)
            begin
                len = ($urandom_range(19) == 0) ? 200 : $urandom_range(60, 5);
                if (len > target - ticks_queued)
                    len = target - ticks_queued;
                queue_session(len);
            end
            else
            begin
                repeat ($urandom_range(5, 1))
                    add_tick($urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_backlog.size() != 0 || tick_ch.valid || expected_results.size() != 0);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PANEL_VOLTAGE_MIN: limits.panel_voltage_min = data;
            CFG_BATTERY_VOLTAGE_MAX: limits.battery_voltage_max = data;
            CFG_CHARGE_CURRENT_MIN: limits.charge_current_min = data[CURRENT_BITS-1:0];
            CFG_DUTY_LOWER_LIMIT: limits.duty_lower_limit = data[LIMIT_BITS-1:0];
            CFG_DUTY_UPPER_LIMIT: limits.duty_upper_limit = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Unused upper bits carry noise, and a write to a spare index must change nothing.
    task automatic apply_limits(cfg_t c);
        logic [CFG_DATA_BITS-1:0] noise;
        noise = $urandom;
        write_register(CFG_PANEL_VOLTAGE_MIN, c.panel_voltage_min);
        write_register(CFG_BATTERY_VOLTAGE_MAX, c.battery_voltage_max);
        write_register(CFG_CHARGE_CURRENT_MIN, {noise[15:12], c.charge_current_min});
        write_register(CFG_DUTY_LOWER_LIMIT, {noise[5:0], c.duty_lower_limit});
        write_register(CFG_DUTY_UPPER_LIMIT, {noise[11:6], c.duty_upper_limit});
        write_register(CFG_INDEX_BITS'($urandom_range(CFG_INDEX_TOP, CFG_DUTY_UPPER_LIMIT + 1)),
                       noise);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_phase(cfg_t c, int send_pct, int stall_pct, int count);
        wait_idle();
        apply_limits(c);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        queue_random(count / 2);
        wait_idle();
        queue_random(count - count / 2);
    endtask

    task automatic flag_mismatch(string field, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : feed_ticks
        tick_t upcoming;
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
                expected_results.push_back(advance_controller(
                    tick_t'{tick_ch.panel_mv, tick_ch.battery_mv, tick_ch.charge_ma}));
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    upcoming = tick_backlog.pop_front();
                    tick_ch.panel_mv <= upcoming.panel_mv;
                    tick_ch.battery_mv <= upcoming.battery_mv;
                    tick_ch.charge_ma <= upcoming.charge_ma;
                    tick_ch.valid <= 1'b1;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        outcome_t want;
        outcome_t got;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.mode = result_ch.mode;
                got.duty = result_ch.duty;
                got.pwm_enable = result_ch.pwm_enable;
                got.flags.pwm_start = result_ch.pwm_start;
                got.flags.postpone = result_ch.postpone;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual mode %0d duty %0d",
                             $time, got.mode, got.duty);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    starts_seen += want.flags.pwm_start;
                    shutdowns_seen += want.flags.postpone;
                    cv_results += (want.mode == MODE_CV);
                    if (got.mode !== want.mode)
                        flag_mismatch("mode", want.mode, got.mode);
                    if (got.duty !== want.duty)
                        flag_mismatch("duty", want.duty, got.duty);
                    if (got.pwm_enable !== want.pwm_enable)
                        flag_mismatch("pwm_enable", want.pwm_enable, got.pwm_enable);
                    if (got.flags.pwm_start !== want.flags.pwm_start)
                        flag_mismatch("pwm_start", want.flags.pwm_start, got.flags.pwm_start);
                    if (got.flags.postpone !== want.flags.postpone)
                        flag_mismatch("postpone", want.flags.postpone, got.flags.postpone);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.panel_mv = '0;
        tick_ch.battery_mv = '0;
        tick_ch.charge_ma = '0;
        result_ch.ready = 1'b0;
        limits = make_limits(PANEL_VOLTAGE_MIN_RESET, BATTERY_VOLTAGE_MAX_RESET,
                             CHARGE_CURRENT_MIN_RESET, DUTY_LOWER_LIMIT_RESET,
                             DUTY_UPPER_LIMIT_RESET);
        ctl_mode = MODE_SHUTDOWN;
        ctl_duty = '0;
        prev_battery_mv = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Start conditions at their edges, one step of each direction, and constant voltage.
        add_tick(0, 0, 0);
        add_tick(65535, 65535, 4095);
        add_tick(12000, 0, 0);
        add_tick(12001, 14399, 4095);
        add_tick(0, 14399, 20);
        add_tick(0, 14000, 100);
        add_tick(0, 14100, 100);
        add_tick(0, 14400, 50);
        add_tick(0, 14400, 0);
        add_tick(0, 14399, 0);
        add_tick(0, 65535, 0);

        // Crossed duty limits: saturating entry into constant voltage, exit to decrement and a low-current shutdown.
        wait_idle();
        apply_limits(make_limits(12000, 14400, 20, 1010, 1000));
        add_tick(0, 14400, 0);
        add_tick(65535, 0, 4095);
        add_tick(0, 14400, 4095);
        add_tick(0, 100, 4095);
        add_tick(0, 200, 19);

        // Full duty span: the increment saturates at the top of the counter.
        wait_idle();
        apply_limits(make_limits(12000, 14400, 20, 0, 1023));
        add_tick(65535, 500, 4095);
        add_tick(0, 100, 4095);
        add_tick(0, 200, 4095);

        run_phase(make_limits(12000, 14400, 20, 100, 900), 0, 0, 220);
        run_phase(make_limits(12000, 14400, 20, 500, 508), 67, 0, 200);
        run_phase(make_limits(0, 65535, 0, 0, 3), 0, 67, 160);
        run_phase(make_limits(65534, 65535, 4095, 1023, 1023), 17, 17, 150);
        run_phase(make_limits(65535, 0, 4095, 0, 1023), 0, 0, 40);
        run_phase(make_limits(13000, 14000, 100, 700, 300), 67, 0, 180);
        run_phase(random_limits(), 0, 67, 170);
        run_phase(random_limits(), 17, 17, 170);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d ticks under %0d register settings and checked %0d results.",
                 ticks_queued, settings_applied, results_checked);
        $display("Results held %0d starts, %0d shutdowns and %0d constant-voltage ticks.",
                 starts_seen, shutdowns_seen, cv_results);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/mppt_po_pkg.sv
design/mppt_po_if.sv
design/mppt_po_cfg.sv
design/mppt_po_step.sv
design/mppt_perturb_observe_controller_top.sv
tb/mppt_perturb_observe_controller_top_test.sv
